[rtl/core/mpsa_pkg.sv]
// ----------------------------------------------------------------------------
// mpsa_pkg
// Shared types and constants of the masked Poisson stencil block.
// ----------------------------------------------------------------------------
package mpsa_pkg;

    localparam int GRID_MAX_DEF = 16;
    localparam int GS_W         = 5;
    localparam int CRD_W        = 4;
    localparam int VAL_W        = 32;
    localparam int RES_W        = 48;
    localparam int ACC_W        = 36;
    localparam int NN_W         = 10;
    localparam int PROD_W       = 64;

    localparam logic [GS_W-1:0] GS_RESET = 5'd16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_APPLY = 1'b1;

    localparam logic REG_GRID_SIZE = 1'b0;
    localparam logic REG_SUBCELL   = 1'b1;

    localparam logic [2:0] NB_XP   = 3'd0;
    localparam logic [2:0] NB_XM   = 3'd1;
    localparam logic [2:0] NB_YP   = 3'd2;
    localparam logic [2:0] NB_YM   = 3'd3;
    localparam logic [2:0] NB_ZM   = 3'd4;
    localparam logic [2:0] NB_ZP   = 3'd5;
    localparam logic [2:0] NB_LAST = NB_ZP;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CREAD,
        S_CEVAL,
        S_NREAD,
        S_NEVAL,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_SCALE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                    cmd;
        logic [CRD_W-1:0]        cell_x;
        logic [CRD_W-1:0]        cell_y;
        logic [CRD_W-1:0]        cell_z;
        logic signed [VAL_W-1:0] level_value;
        logic signed [VAL_W-1:0] pressure_value;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic                    is_fluid;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [VAL_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/core/mpsa_ram.sv]
// ----------------------------------------------------------------------------
// mpsa_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mpsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mpsa_div.sv]
// ----------------------------------------------------------------------------
// mpsa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpsa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpsa_pkg::t_div_req i_req,
    output mpsa_pkg::t_div_rsp o_rsp
);
    import mpsa_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [5:0]               r_cnt;
    logic [VAL_W-1:0]         r_rem;
    logic [VAL_W-1:0]         r_dvs;
    logic [PROD_W-1:0]        r_dq;
    logic [VAL_W:0]           w_rem_sh;
    logic [VAL_W+1:0]         w_diff;
    logic                     w_ge;

    assign w_rem_sh = {r_rem, r_dq[PROD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dvs};
    assign w_ge     = !w_diff[VAL_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_dq  <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VAL_W-1:0] : w_rem_sh[VAL_W-1:0];
            r_dq  <= {r_dq[PROD_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dq;

endmodule

[rtl/core/masked_poisson_stencil_apply.sv]
// ----------------------------------------------------------------------------
// masked_poisson_stencil_apply
// Seven-point Poisson operator over a cubic grid, masked by fluid cells.
// ----------------------------------------------------------------------------
// A load item writes one cell's level and pressure into two single-port RAMs.
// An apply item reads the centre and then its six neighbours one at a time
// through those RAM ports; a non-fluid centre skips the neighbour reads. In
// subcell mode each non-fluid neighbour adds a multiply and a 64-step
// bit-serial division. One item is worked on at a time; a finished result
// waits in the output register.
module masked_poisson_stencil_apply #(
    parameter int GRID_MAX = mpsa_pkg::GRID_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpsa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpsa_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mpsa_pkg::*;

    localparam int DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 5;

    t_state r_state;
    t_state n_state;

    logic [GS_W-1:0]          r_gs;
    logic                     r_sub;
    logic [CW-1:0]            r_cx;
    logic [CW-1:0]            r_cy;
    logic [CW-1:0]            r_cz;
    logic [2:0]               r_nb;
    logic signed [VAL_W-1:0]  r_lc;
    logic signed [VAL_W-1:0]  r_xc;
    logic signed [VAL_W-1:0]  r_ln;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [RES_W-1:0]  r_res;
    logic                     r_fluid;
    logic                     r_ov;
    t_out_item                r_out;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic [GS_W-1:0]          w_n;
    logic [CW-1:0]            w_nm1;
    logic [NN_W-1:0]          w_nn;
    logic [CW-1:0]            w_ax;
    logic [CW-1:0]            w_ay;
    logic [CW-1:0]            w_az;
    logic [CW-1:0]            w_ccx;
    logic [CW-1:0]            w_ccy;
    logic [CW-1:0]            w_ccz;
    logic [AW-1:0]            w_caddr;
    logic [AW-1:0]            w_naddr;
    logic [AW-1:0]            w_laddr;
    logic                     w_lok;
    logic [AW-1:0]            w_addr;
    logic                     w_we;
    logic signed [VAL_W-1:0]  w_lrd;
    logic signed [VAL_W-1:0]  w_vrd;
    logic                     w_last;
    logic                     w_nb_frac;
    logic                     w_neg;
    logic signed [VAL_W-1:0]  w_term;
    logic signed [RES_W-1:0]  w_scaled;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ov || !i_out_stall;

    always_comb begin
        if (r_gs < GS_W'(2)) begin
            w_n = GS_W'(2);
        end else if (int'(r_gs) > GRID_MAX) begin
            w_n = GS_W'(GRID_MAX);
        end else begin
            w_n = r_gs;
        end
    end

    assign w_nm1 = CW'(w_n) - CW'(1);
    assign w_nn  = NN_W'(w_n) * NN_W'(w_n);

    assign w_ccx = ({1'b0, i_in_item.cell_x} > w_nm1) ? w_nm1 : {1'b0, i_in_item.cell_x};
    assign w_ccy = ({1'b0, i_in_item.cell_y} > w_nm1) ? w_nm1 : {1'b0, i_in_item.cell_y};
    assign w_ccz = ({1'b0, i_in_item.cell_z} > w_nm1) ? w_nm1 : {1'b0, i_in_item.cell_z};

    always_comb begin
        w_ax = r_cx;
        w_ay = r_cy;
        w_az = r_cz;
        case (r_nb)
            NB_XP: w_ax = (r_cx >= w_nm1) ? w_nm1 : r_cx + CW'(1);
            NB_XM: w_ax = (r_cx == '0) ? '0 : r_cx - CW'(1);
            NB_YP: w_ay = (r_cy >= w_nm1) ? w_nm1 : r_cy + CW'(1);
            NB_YM: w_ay = (r_cy == '0) ? '0 : r_cy - CW'(1);
            NB_ZM: w_az = (r_cz == '0) ? '0 : r_cz - CW'(1);
            NB_ZP: w_az = (r_cz >= w_nm1) ? w_nm1 : r_cz + CW'(1);
            default: w_ax = r_cx;
        endcase
    end

    assign w_caddr = AW'(int'(r_cx) * GRID_MAX * GRID_MAX + int'(r_cy) * GRID_MAX
                         + int'(r_cz));
    assign w_naddr = AW'(int'(w_ax) * GRID_MAX * GRID_MAX + int'(w_ay) * GRID_MAX
                         + int'(w_az));
    assign w_laddr = AW'(int'(i_in_item.cell_x) * GRID_MAX * GRID_MAX
                         + int'(i_in_item.cell_y) * GRID_MAX + int'(i_in_item.cell_z));
    assign w_lok   = (int'(i_in_item.cell_x) < GRID_MAX) && (int'(i_in_item.cell_y) < GRID_MAX)
                     && (int'(i_in_item.cell_z) < GRID_MAX);

    assign w_last    = (r_nb == NB_LAST);
    assign w_nb_frac = !w_lrd[VAL_W-1] && r_sub;

    assign w_neg = !r_prod[PROD_W-1];
    always_comb begin
        if (w_neg) begin
            if (w_div_rsp.quotient > 64'd2147483648) begin
                w_term = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                w_term = -$signed(w_div_rsp.quotient[VAL_W-1:0]);
            end
        end else begin
            if (w_div_rsp.quotient > 64'd2147483647) begin
                w_term = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                w_term = $signed(w_div_rsp.quotient[VAL_W-1:0]);
            end
        end
    end

    assign w_scaled = RES_W'(r_acc) * $signed(RES_W'(w_nn));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_item.cmd == CMD_APPLY) begin
                    n_state = S_CREAD;
                end
            end
            S_CREAD: n_state = S_CEVAL;
            S_CEVAL: n_state = w_lrd[VAL_W-1] ? S_NREAD : S_SCALE;
            S_NREAD: n_state = S_NEVAL;
            S_NEVAL: begin
                if (w_nb_frac) begin
                    n_state = S_MUL;
                end else begin
                    n_state = w_last ? S_SCALE : S_NREAD;
                end
            end
            S_MUL:  n_state = S_DIVS;
            S_DIVS: n_state = S_DIVW;
            S_DIVW: begin
                if (w_div_rsp.done) begin
                    n_state = w_last ? S_SCALE : S_NREAD;
                end
            end
            S_SCALE: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall        = (r_state != S_IDLE);
        w_we              = 1'b0;
        w_addr            = w_caddr;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_div_req.divisor  = VAL_W'(-r_lc);
        unique case (r_state)
            S_IDLE: begin
                w_addr = w_laddr;
                w_we   = w_in_acc && (i_in_item.cmd == CMD_LOAD) && w_lok;
            end
            S_NREAD: w_addr = w_naddr;
            S_DIVS:  w_div_req.start = 1'b1;
            default: w_addr = w_caddr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gs    <= GS_RESET;
            r_sub   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                unique case (paddr[2])
                    REG_GRID_SIZE: r_gs  <= pwdata[GS_W-1:0];
                    REG_SUBCELL:   r_sub <= pwdata[0];
                    default:       r_sub <= r_sub;
                endcase
            end
            if (r_state == S_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cx <= w_ccx;
                r_cy <= w_ccy;
                r_cz <= w_ccz;
            end
            S_CEVAL: begin
                r_lc    <= w_lrd;
                r_xc    <= w_vrd;
                r_fluid <= w_lrd[VAL_W-1];
                r_nb    <= NB_XP;
                r_acc   <= w_lrd[VAL_W-1] ? ACC_W'(w_vrd) * ACC_W'(6) : '0;
            end
            S_NEVAL: begin
                r_ln <= w_lrd;
                if (w_lrd[VAL_W-1]) begin
                    r_acc <= r_acc - ACC_W'(w_vrd);
                end
                if (!w_nb_frac) begin
                    r_nb <= r_nb + 3'd1;
                end
            end
            S_MUL: r_prod <= r_ln * r_xc;
            S_DIVW: begin
                if (w_div_rsp.done) begin
                    r_acc <= r_acc - ACC_W'(w_term);
                    r_nb  <= r_nb + 3'd1;
                end
            end
            S_SCALE: r_res <= w_scaled;
            S_OUT: begin
                if (w_out_free) begin
                    r_out.result_value <= r_res;
                    r_out.is_fluid     <= r_fluid;
                end
            end
            default: r_res <= r_res;
        endcase
    end

    mpsa_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_level_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(i_in_item.level_value),
        .o_rdata(w_lrd)
    );

    mpsa_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(i_in_item.pressure_value),
        .o_rdata(w_vrd)
    );

    mpsa_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_SUBCELL) ? {31'd0, r_sub} : {27'd0, r_gs};

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE))
        else $error("store written during an apply");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ov && i_out_stall) |=> (r_state == S_OUT))
        else $error("result left while output register was full");

    a_nb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NREAD) |-> (r_nb <= NB_LAST))
        else $error("neighbour index out of range");

endmodule
